@@ rtl/sha1_pkg.sv @@
// shared types and constants for the sha-1 stream hash
// no dependencies
`default_nettype none
package sha1_pkg;
	localparam int QueueDepth = 4;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PadByte = 8'h80;

	// classified item passed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} item_t;
endpackage
`default_nettype wire

@@ rtl/sha1_front.sv @@
// front end: drops empty non-final items, queues the rest
// depends on sha1_pkg
`default_nettype none
module sha1_front
	import sha1_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire item_t in_item,
	output logic       q_valid,
	input  wire logic  q_pop,
	output item_t      q_item
);
	localparam int AW = $clog2(Depth);
	item_t mem [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == (AW+1)'(Depth));
	assign push = in_valid && !in_stall && (in_item.has || in_item.last);
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_item = mem[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= in_item;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(Depth)) else $error("queue overflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count");
endmodule
`default_nettype wire

@@ rtl/sha1_core.sv @@
// back end: byte packing, padding and one sha-1 round per cycle
// depends on sha1_pkg
`default_nettype none
module sha1_core
	import sha1_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	output logic       q_pop,
	input  wire item_t q_item,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [63:0] digest_high,
	output logic [63:0] digest_mid,
	output logic [31:0] digest_low
);
	localparam logic [2:0] StIdle = 3'd0, StRound = 3'd1, StPad = 3'd2,
		StFin = 3'd3, StLen = 3'd4, StOut = 3'd5;
	logic [2:0] st_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [60:0] cnt_q;
	logic [6:0] rnd_q;
	logic [5:0] pos_q;
	logic last_q, padfin_q, lenblk_q;
	logic take, wr_byte;
	logic [7:0] wr_data;
	logic [31:0] wnew, w, f, k, t;

	assign q_pop = (st_q == StIdle);
	assign take = q_pop && q_valid;

	// byte that enters the schedule this cycle: message byte or padding
	assign wr_byte = (take && q_item.has) || (st_q == StPad);
	assign wr_data = (st_q == StPad) ? (padfin_q ? 8'h00 : PadByte) : q_item.data;

	// schedule word and round function
	always_comb begin
		wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w = (rnd_q < 7'd16) ? w_q[0] : {wnew[30:0], wnew[31]};
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;
	end

	// schedule: bytes shift into word 15, length fills the last two words,
	// rounds rotate the window
	always_ff @(posedge clk) begin
		if (wr_byte) begin
			if (pos_q[1:0] == 2'd0) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= {24'd0, wr_data};
			end else begin
				w_q[15] <= {w_q[15][23:0], wr_data};
			end
		end else if (st_q == StLen) begin
			for (int i = 0; i < 14; i++) w_q[i] <= w_q[i+2];
			w_q[14] <= cnt_q[60:29];
			w_q[15] <= {cnt_q[28:0], 3'd0};
		end else if (st_q == StRound) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w;
		end
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle; cnt_q <= '0; rnd_q <= '0; pos_q <= '0;
			last_q <= 1'b0; padfin_q <= 1'b0; lenblk_q <= 1'b0; out_valid <= 1'b0;
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			digest_high <= '0; digest_mid <= '0; digest_low <= '0;
		end else begin
			unique case (st_q)
				StIdle: if (take) begin
					last_q <= q_item.last;
					padfin_q <= 1'b0;
					if (q_item.has) begin
						cnt_q <= cnt_q + 1'b1;
						pos_q <= pos_q + 1'b1;
						if (pos_q == 6'd63) begin
							a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
							d_q <= h_q[3]; e_q <= h_q[4];
							st_q <= StRound;
						end else if (q_item.last) st_q <= StPad;
					end else if (q_item.last) st_q <= StPad;
				end
				StPad: begin
					padfin_q <= 1'b1;
					pos_q <= pos_q + 1'b1;
					if (pos_q == 6'd63) begin
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
						d_q <= h_q[3]; e_q <= h_q[4];
						st_q <= StRound;
					end else if (pos_q == 6'd55) st_q <= StLen;
				end
				StLen: begin
					pos_q <= '0;
					lenblk_q <= 1'b1;
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
					d_q <= h_q[3]; e_q <= h_q[4];
					st_q <= StRound;
				end
				StRound: begin
					e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q; a_q <= t;
					if (rnd_q == 7'd79) begin
						rnd_q <= '0;
						st_q <= StFin;
					end else rnd_q <= rnd_q + 1'b1;
				end
				StFin: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (lenblk_q) st_q <= StOut;
					else if (last_q) st_q <= StPad;
					else st_q <= StIdle;
				end
				// digest goes out once the result register is free
				StOut: if (!out_valid || !out_stall) begin
					digest_high <= {h_q[0], h_q[1]};
					digest_mid <= {h_q[2], h_q[3]};
					digest_low <= h_q[4];
					h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
					cnt_q <= '0;
					last_q <= 1'b0; padfin_q <= 1'b0; lenblk_q <= 1'b0;
					st_q <= StIdle;
				end
				default: st_q <= StIdle;
			endcase
			// result register: load from the output state, clear once taken
			if (st_q == StOut && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == StRound |-> rnd_q < 7'd80) else $error("round range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(digest_high)
		&& $stable(digest_low)) else $error("result lost");
	a_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != StIdle |-> !q_pop) else $error("pop while busy");
	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == StLen |-> pos_q == 6'd56) else $error("length position");
endmodule
`default_nettype wire

@@ rtl/sha1_stream_hash.sv @@
// top level of the sha-1 stream hash
// depends on sha1_pkg, sha1_front, sha1_core
//
// usage: one message byte per input item (msg_byte with has_byte), is_last
// closes the message; an item with neither flag is dropped. the front queue
// holds up to Depth items while the back end hashes.
// each byte enters the back end at one per cycle while it is idle; a full
// 64-byte block then runs 80 rounds, one per cycle, and a chaining step,
// during which no bytes are taken. the final item pads the block one byte
// per cycle up to byte 55, then the length is loaded, the block is hashed
// and the result is loaded; with fewer than 9 bytes left the padding spills
// into one more block, hashed before the padding goes on in the next one.
// the result register holds while out_stall is high; a second digest waits
// in the back end, which then takes no items until the register frees, and
// the queue fills and raises in_stall. reset clears the chaining words to
// the sha-1 initial values, the byte count and the queue.
`default_nettype none
module sha1_stream_hash
	import sha1_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  msg_byte,
	input  wire logic        has_byte,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      digest_high,
	output logic [63:0]      digest_mid,
	output logic [31:0]      digest_low
);
	item_t in_item, q_item;
	logic q_valid, q_pop;
	assign in_item = '{data: msg_byte, has: has_byte, last: is_last};

	sha1_front #(.Depth(Depth)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.q_valid, .q_pop, .q_item
	);
	sha1_core u_core (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.out_valid, .out_stall, .digest_high, .digest_mid, .digest_low
	);
endmodule
`default_nettype wire
